/* rtl/triangle_unit_normal_defines.svh */
// assertion macros for the triangle unit normal block
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tun implication check failed");
`define TUN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tun next-cycle check failed");
`else
`define TUN_ASSERT_IMP(lbl, ante, cons)
`define TUN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/tun_pkg.sv */
// shared widths, constants and types of the triangle unit normal pipeline
`timescale 1ns / 1ps
package tun_pkg;
    localparam int COORD_W     = 16;
    localparam int EDGE_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * EDGE_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int MAG_W       = CROSS_W - 1;
    localparam int NMAG_W      = 31;
    localparam int SQ_W        = 2 * NMAG_W;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int FRAC_W      = 14;
    localparam int Q_W         = FRAC_W + 1;
    localparam int NUM_W       = NMAG_W + FRAC_W + 1;
    localparam int OUT_W       = 16;
    localparam int NORM_STAGES = 3;
    localparam int NORM_SH [0:2*NORM_STAGES-1] = '{32, 16, 8, 4, 2, 1};
    localparam int DIV_STEPS   = Q_W;

    typedef struct packed {
        logic                   degen;
        logic [2:0]             neg;
        logic [2:0][NMAG_W-1:0] mg;
    } tun_side_t;

    typedef struct packed {
        logic                degen;
        logic [2:0]          neg;
        logic [2:0][Q_W-1:0] q;
    } tun_res_t;
endpackage

/* rtl/tun_isqrt.sv */
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`include "triangle_unit_normal_defines.svh"
module tun_isqrt
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic [tun_pkg::SUM_W-1:0]      in_sum,
    input  tun_pkg::tun_side_t             in_side,
    output logic                           out_vld,
    output logic [tun_pkg::ROOT_W-1:0]     out_root,
    output tun_pkg::tun_side_t             out_side
);
    logic                          vld_reg  [0:tun_pkg::ROOT_W-1];
    logic [tun_pkg::SUM_W-1:0]     rem_reg  [0:tun_pkg::ROOT_W-1];
    logic [tun_pkg::ROOT_W-1:0]    root_reg [0:tun_pkg::ROOT_W-1];
    tun_pkg::tun_side_t            side_reg [0:tun_pkg::ROOT_W-1];
    logic [tun_pkg::SUM_W-1:0]     rem_next  [0:tun_pkg::ROOT_W-1];
    logic [tun_pkg::ROOT_W-1:0]    root_next [0:tun_pkg::ROOT_W-1];

    always_comb
    begin
        logic [tun_pkg::SUM_W-1:0]  rc;
        logic [tun_pkg::SUM_W-1:0]  tst;
        logic [tun_pkg::ROOT_W-1:0] oc;
        for (int k = 0; k < tun_pkg::ROOT_W; k++)
        begin
            rc = (k == 0) ? in_sum : rem_reg[(k == 0) ? 0 : k - 1];
            oc = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k - 1];
            // trial term is 2*root*2^b + 4^b, the root bits sit above b
            tst = ({{(tun_pkg::SUM_W - tun_pkg::ROOT_W){1'b0}}, oc}
                   << (tun_pkg::ROOT_W - k))
                  | ({{(tun_pkg::SUM_W - 1){1'b0}}, 1'b1}
                   << (2 * (tun_pkg::ROOT_W - 1 - k)));
            if (rc >= tst)
            begin
                rem_next[k]  = rc - tst;
                root_next[k] = oc | ({{(tun_pkg::ROOT_W - 1){1'b0}}, 1'b1}
                                     << (tun_pkg::ROOT_W - 1 - k));
            end
            else
            begin
                rem_next[k]  = rc;
                root_next[k] = oc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tun_pkg::ROOT_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < tun_pkg::ROOT_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 0; k < tun_pkg::ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
            for (int k = 1; k < tun_pkg::ROOT_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[tun_pkg::ROOT_W-1];
    assign out_root = root_reg[tun_pkg::ROOT_W-1];
    assign out_side = side_reg[tun_pkg::ROOT_W-1];

    // normalized sum is at least 2^60, so the root has one of its top two bits set
    `TUN_ASSERT_IMP(a_root_range, out_vld && !out_side.degen,
        out_root[tun_pkg::ROOT_W-1:tun_pkg::ROOT_W-2] != 2'b00)
endmodule

/* rtl/tun_div.sv */
// pipelined restoring divider: three rounded quotients, one bit per stage
`timescale 1ns / 1ps
module tun_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [tun_pkg::ROOT_W-1:0]  in_len,
    input  tun_pkg::tun_side_t          in_side,
    output logic                        out_vld,
    output tun_pkg::tun_res_t           out_res
);
    localparam int LAST = tun_pkg::DIV_STEPS;

    logic                             vld_reg [0:LAST];
    logic [tun_pkg::ROOT_W-1:0]       len_reg [0:LAST];
    logic                             dg_reg  [0:LAST];
    logic [2:0]                       neg_reg [0:LAST];
    logic [2:0][tun_pkg::NUM_W-1:0]   rem_reg [0:LAST];
    logic [2:0][tun_pkg::Q_W-1:0]     q_reg   [0:LAST];
    logic [2:0][tun_pkg::NUM_W-1:0]   rem_next [1:LAST];
    logic [2:0][tun_pkg::Q_W-1:0]     q_next   [1:LAST];
    logic [2:0][tun_pkg::NUM_W-1:0]   num_next;

    always_comb
    begin
        logic [tun_pkg::NUM_W-1:0] dv;
        // numerator mag * 2^frac + len/2 gives round half up
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = tun_pkg::NUM_W'({in_side.mg[i], {tun_pkg::FRAC_W{1'b0}}})
                        + tun_pkg::NUM_W'(in_len >> 1);
        end
        for (int k = 1; k <= LAST; k++)
        begin
            dv = tun_pkg::NUM_W'(len_reg[k-1]) << (LAST - k);
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[k-1][i] >= dv)
                begin
                    rem_next[k][i] = rem_reg[k-1][i] - dv;
                    q_next[k][i]   = q_reg[k-1][i]
                                   | (tun_pkg::Q_W'(1) << (LAST - k));
                end
                else
                begin
                    rem_next[k][i] = rem_reg[k-1][i];
                    q_next[k][i]   = q_reg[k-1][i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= in_len;
            dg_reg[0]  <= in_side.degen;
            neg_reg[0] <= in_side.neg;
            rem_reg[0] <= num_next;
            q_reg[0]   <= '0;
            for (int k = 1; k <= LAST; k++)
            begin
                len_reg[k] <= len_reg[k-1];
                dg_reg[k]  <= dg_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign out_vld       = vld_reg[LAST];
    assign out_res.degen = dg_reg[LAST];
    assign out_res.neg   = neg_reg[LAST];
    assign out_res.q     = q_reg[LAST];
endmodule

/* rtl/triangle_unit_normal.sv */
// top level: triangle face normal, cross product scaled to unit length
`timescale 1ns / 1ps
`include "triangle_unit_normal_defines.svh"
// usage
//   input channel in_valid / in_ready carries the nine corner coordinates
//   a_*, b_*, c_* of one triangle as signed 16-bit fixed point
//   output channel out_valid / out_ready carries norm_x/y/z as signed Q1.14
//   and the degenerate flag (zero cross product, normal forced to zero)
// throughput: one triangle per cycle while a stalled receiver does not hold the pipeline;
//   the pipeline is 58 register stages, set by the 32-stage square root and the
//   16-stage divider
// every stage moves on one shared enable; the enable is low only while a
//   result sits in the output register and out_ready is low, so the input
//   keeps taking transactions whenever the output register is free or drains
// a stalled receiver freezes the whole pipeline with nothing lost or repeated
// reset clears all valid bits; payload registers are not reset
// the block has no configuration and keeps no state between triangles
module triangle_unit_normal
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [tun_pkg::COORD_W-1:0] a_x,
    input  logic signed [tun_pkg::COORD_W-1:0] a_y,
    input  logic signed [tun_pkg::COORD_W-1:0] a_z,
    input  logic signed [tun_pkg::COORD_W-1:0] b_x,
    input  logic signed [tun_pkg::COORD_W-1:0] b_y,
    input  logic signed [tun_pkg::COORD_W-1:0] b_z,
    input  logic signed [tun_pkg::COORD_W-1:0] c_x,
    input  logic signed [tun_pkg::COORD_W-1:0] c_y,
    input  logic signed [tun_pkg::COORD_W-1:0] c_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tun_pkg::OUT_W-1:0]   norm_x,
    output logic signed [tun_pkg::OUT_W-1:0]   norm_y,
    output logic signed [tun_pkg::OUT_W-1:0]   norm_z,
    output logic                               degenerate
);
    localparam int NS = tun_pkg::NORM_STAGES;

    logic en;

    logic                              v1_reg;
    logic signed [tun_pkg::EDGE_W-1:0] e1_reg [0:2];
    logic signed [tun_pkg::EDGE_W-1:0] e2_reg [0:2];
    logic                              v2_reg;
    logic signed [tun_pkg::PROD_W-1:0] pr_reg [0:5];
    logic                              v3_reg;
    logic [tun_pkg::MAG_W-1:0]         mg3_reg [0:2];
    logic [2:0]                        neg3_reg;
    logic [tun_pkg::MAG_W-1:0]         mg3_next [0:2];
    logic [2:0]                        neg3_next;

    logic                              nm_vld_reg [0:NS];
    logic [2:0][tun_pkg::MAG_W-1:0]    nm_mg_reg  [0:NS];
    logic [tun_pkg::MAG_W-1:0]         nm_big_reg [0:NS];
    logic [2:0]                        nm_neg_reg [0:NS];
    logic                              nm_dg_reg  [0:NS];
    logic [2:0][tun_pkg::MAG_W-1:0]    nm_mg_next  [1:NS];
    logic [tun_pkg::MAG_W-1:0]         nm_big_next [1:NS];
    logic [tun_pkg::MAG_W-1:0]         big4_next;

    logic                              vsq_reg;
    logic [tun_pkg::SQ_W-1:0]          sq_reg [0:2];
    tun_pkg::tun_side_t                sq_side_reg;
    tun_pkg::tun_side_t                sq_side_next;
    logic                              vsum_reg;
    logic [tun_pkg::SUM_W-1:0]         sum_reg;
    tun_pkg::tun_side_t                sum_side_reg;

    logic                              sr_vld;
    logic [tun_pkg::ROOT_W-1:0]        sr_root;
    tun_pkg::tun_side_t                sr_side;
    logic                              dv_vld;
    tun_pkg::tun_res_t                 dv_res;

    logic                              out_valid_reg;
    logic [tun_pkg::OUT_W-1:0]         nx_reg;
    logic [tun_pkg::OUT_W-1:0]         ny_reg;
    logic [tun_pkg::OUT_W-1:0]         nz_reg;
    logic                              dg_reg;
    logic [tun_pkg::OUT_W-1:0]         nout_next [0:2];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // edges b-a and c-a
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= $signed({b_x[tun_pkg::COORD_W-1], b_x})
                       - $signed({a_x[tun_pkg::COORD_W-1], a_x});
            e1_reg[1] <= $signed({b_y[tun_pkg::COORD_W-1], b_y})
                       - $signed({a_y[tun_pkg::COORD_W-1], a_y});
            e1_reg[2] <= $signed({b_z[tun_pkg::COORD_W-1], b_z})
                       - $signed({a_z[tun_pkg::COORD_W-1], a_z});
            e2_reg[0] <= $signed({c_x[tun_pkg::COORD_W-1], c_x})
                       - $signed({a_x[tun_pkg::COORD_W-1], a_x});
            e2_reg[1] <= $signed({c_y[tun_pkg::COORD_W-1], c_y})
                       - $signed({a_y[tun_pkg::COORD_W-1], a_y});
            e2_reg[2] <= $signed({c_z[tun_pkg::COORD_W-1], c_z})
                       - $signed({a_z[tun_pkg::COORD_W-1], a_z});
        end
    end

    // cross product partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= e1_reg[1] * e2_reg[2];
            pr_reg[1] <= e1_reg[2] * e2_reg[1];
            pr_reg[2] <= e1_reg[2] * e2_reg[0];
            pr_reg[3] <= e1_reg[0] * e2_reg[2];
            pr_reg[4] <= e1_reg[0] * e2_reg[1];
            pr_reg[5] <= e1_reg[1] * e2_reg[0];
        end
    end

    // cross components as sign and magnitude
    always_comb
    begin
        logic [tun_pkg::CROSS_W-1:0] cr;
        for (int i = 0; i < 3; i++)
        begin
            cr = {pr_reg[2*i][tun_pkg::PROD_W-1], pr_reg[2*i]}
               - {pr_reg[2*i+1][tun_pkg::PROD_W-1], pr_reg[2*i+1]};
            neg3_next[i] = cr[tun_pkg::CROSS_W-1];
            mg3_next[i]  = cr[tun_pkg::CROSS_W-1] ? tun_pkg::MAG_W'(~cr + 1'b1)
                                                   : tun_pkg::MAG_W'(cr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mg3_reg  <= mg3_next;
            neg3_reg <= neg3_next;
        end
    end

    // largest magnitude, then leading-zero normalization over three stages
    always_comb
    begin
        logic [tun_pkg::MAG_W-1:0]      bg;
        logic [2:0][tun_pkg::MAG_W-1:0] mv;
        int                             sh;
        big4_next = (mg3_reg[0] > mg3_reg[1]) ? mg3_reg[0] : mg3_reg[1];
        big4_next = (mg3_reg[2] > big4_next) ? mg3_reg[2] : big4_next;
        for (int k = 1; k <= NS; k++)
        begin
            bg = nm_big_reg[k-1];
            mv = nm_mg_reg[k-1];
            for (int j = 0; j < 2; j++)
            begin
                sh = tun_pkg::NORM_SH[2*(k-1)+j];
                if ((bg >> (tun_pkg::MAG_W - sh)) == '0)
                begin
                    bg = bg << sh;
                    for (int i = 0; i < 3; i++)
                    begin
                        mv[i] = mv[i] << sh;
                    end
                end
            end
            nm_big_next[k] = bg;
            nm_mg_next[k]  = mv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_big_reg[0] <= big4_next;
            nm_mg_reg[0]  <= {mg3_reg[2], mg3_reg[1], mg3_reg[0]};
            nm_neg_reg[0] <= neg3_reg;
            nm_dg_reg[0]  <= (big4_next == '0);
            for (int k = 1; k <= NS; k++)
            begin
                nm_big_reg[k] <= nm_big_next[k];
                nm_mg_reg[k]  <= nm_mg_next[k];
                nm_neg_reg[k] <= nm_neg_reg[k-1];
                nm_dg_reg[k]  <= nm_dg_reg[k-1];
            end
        end
    end

    // top bit at position MAG_W-1, keep NMAG_W bits so the largest is in [2^30, 2^31)
    always_comb
    begin
        sq_side_next.degen = nm_dg_reg[NS];
        sq_side_next.neg   = nm_neg_reg[NS];
        for (int i = 0; i < 3; i++)
        begin
            sq_side_next.mg[i] =
                nm_mg_reg[NS][i][tun_pkg::MAG_W-1 -: tun_pkg::NMAG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_side_next.mg[i] * sq_side_next.mg[i];
            end
            sq_side_reg  <= sq_side_next;
            sum_reg      <= tun_pkg::SUM_W'(sq_reg[0]) + tun_pkg::SUM_W'(sq_reg[1])
                          + tun_pkg::SUM_W'(sq_reg[2]);
            sum_side_reg <= sq_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vsq_reg  <= 1'b0;
            vsum_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                nm_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            nm_vld_reg[0] <= v3_reg;
            for (int k = 1; k <= NS; k++)
            begin
                nm_vld_reg[k] <= nm_vld_reg[k-1];
            end
            vsq_reg  <= nm_vld_reg[NS];
            vsum_reg <= vsq_reg;
        end
    end

    tun_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vsum_reg),
        .in_sum   (sum_reg),
        .in_side  (sum_side_reg),
        .out_vld  (sr_vld),
        .out_root (sr_root),
        .out_side (sr_side)
    );

    tun_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sr_vld),
        .in_len  (sr_root),
        .in_side (sr_side),
        .out_vld (dv_vld),
        .out_res (dv_res)
    );

    // clamp to one, apply sign, force zero on a degenerate triangle
    always_comb
    begin
        logic [tun_pkg::Q_W-1:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = (dv_res.q[i] > (tun_pkg::Q_W'(1) << tun_pkg::FRAC_W))
               ? (tun_pkg::Q_W'(1) << tun_pkg::FRAC_W) : dv_res.q[i];
            if (dv_res.degen)
            begin
                nout_next[i] = '0;
            end
            else if (dv_res.neg[i])
            begin
                nout_next[i] = tun_pkg::OUT_W'(0) - tun_pkg::OUT_W'(qc);
            end
            else
            begin
                nout_next[i] = tun_pkg::OUT_W'(qc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= nout_next[0];
            ny_reg <= nout_next[1];
            nz_reg <= nout_next[2];
            dg_reg <= dv_res.degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign norm_x     = $signed(nx_reg);
    assign norm_y     = $signed(ny_reg);
    assign norm_z     = $signed(nz_reg);
    assign degenerate = dg_reg;

    `TUN_ASSERT_IMP(a_degen_zero, out_valid && degenerate,
        norm_x == 0 && norm_y == 0 && norm_z == 0)
    `TUN_ASSERT_IMP(a_norm_range, out_valid && !degenerate,
        norm_x <= 16'sd16384 && norm_x >= -16'sd16384
        && norm_y <= 16'sd16384 && norm_y >= -16'sd16384
        && norm_z <= 16'sd16384 && norm_z >= -16'sd16384)
    `TUN_ASSERT_IMP(a_norm_nonzero, out_valid && !degenerate,
        norm_x != 0 || norm_y != 0 || norm_z != 0)
endmodule
